@@ sv/wmss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_pkg
// Shared types and constants of the windowed maximum subsequence sum block.
// ----------------------------------------------------------------------------
package wmss_pkg;

    localparam int SUM_W = 32;
    localparam int IDX_W = 16;
    localparam int WIN_W = 7;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_SHIFT  = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [SUM_W-1:0] cur;
        logic [IDX_W-1:0]        idx;
        logic                    cur_pos;
        logic                    shift_full;
    } cell_ctrl_t;

endpackage

@@ sv/wmss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_cell
// One queue cell: holds a candidate, compares against the new sum, and
// shifts, keeps, loads or drops its entry.
// ----------------------------------------------------------------------------
module wmss_cell
    import wmss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  entry_t     right_in,
    input  logic       left_keep,
    output entry_t     ent,
    output logic       keep
);

    logic                    valid_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    load_new;

    assign keep     = valid_reg && !(sum_reg < ctrl.cur);
    assign load_new = ctrl.cur_pos && left_keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (ctrl.op)
                OP_SHIFT: begin
                    valid_reg <= right_in.valid;
                end
                OP_UPDATE: begin
                    if (ctrl.shift_full) begin
                        valid_reg <= right_in.valid;
                    end else if (!keep) begin
                        valid_reg <= load_new;
                    end
                end
                OP_CLEAR: begin
                    valid_reg <= 1'b0;
                end
                default: begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_SHIFT: begin
                idx_reg <= right_in.idx;
                sum_reg <= right_in.sum;
            end
            OP_UPDATE: begin
                if (ctrl.shift_full) begin
                    idx_reg <= right_in.idx;
                    sum_reg <= right_in.sum;
                end else if (!keep && load_new) begin
                    idx_reg <= ctrl.idx;
                    sum_reg <= ctrl.cur;
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign ent = '{valid: valid_reg, idx: idx_reg, sum: sum_reg};

endmodule

@@ sv/windowed_max_subsequence_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_max_subsequence_sum
// Best windowed subsequence sum per sample, kept in a chain of queue cells
// holding a monotonic decreasing list of positive candidates.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                       Contents
// s_       in   s_tvalid/tready/tdata/tlast   sample, seq_end
// m_       out  m_tvalid/tready/tdata/tlast   sum_ending_here, best_sum, is_final
// cfg_     in   cfg_we/cfg_wdata              window_len
//
// Each sample passes the idle, expire and update states: in expire the
// expired front cells are retired one per cycle, then the sum is formed,
// then all cells compare and update at once.
// aresetn is synchronous, active low; it empties the queue, sets window_len 1.
// A waiting result stalls only the final update step of the next sample.
// ----------------------------------------------------------------------------
module windowed_max_subsequence_sum
    import wmss_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // sample
    input  logic                                 s_tlast,   // seq_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*SUM_W-1:0]                   m_tdata,   // sum_ending_here, best_sum
    output logic                                 m_tlast,   // is_final
    input  logic                                 cfg_we,
    input  logic [WIN_W-1:0]                     cfg_wdata  // window_len
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    localparam logic signed [SUM_W-1:0] MOST_NEG =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(WINDOW_DEPTH);

    logic [1:0]                    state_reg, state_next;
    logic [SAMPLE_WIDTH-1:0]       sample_reg;
    logic                          last_reg;
    logic signed [SUM_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]              item_index_reg;
    logic signed [SUM_W-1:0]       best_reg, best_next;
    logic [WIN_W-1:0]              window_reg;
    logic                          m_valid_reg;
    logic [2*SUM_W-1:0]            m_data_reg;
    logic                          m_last_reg;

    entry_t                        ents [WINDOW_DEPTH+1];
    logic                          keeps [WINDOW_DEPTH+1];
    cell_ctrl_t                    ctrl;
    entry_t                        front;
    logic [IDX_W-1:0]              win;
    logic [IDX_W-1:0]              age;
    logic                          expired;
    logic                          advance;
    logic signed [SUM_W:0]         sum_wide;

    assign front   = ents[0];
    assign win     = (32'(window_reg) > WINDOW_DEPTH) ? DEPTH_IDX : IDX_W'(window_reg);
    assign age     = item_index_reg - front.idx;
    assign expired = front.valid && (age > win);
    assign advance = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        sum_wide = {{(SUM_W-SAMPLE_WIDTH+1){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};
        if (front.valid) begin
            sum_wide = sum_wide + {front.sum[SUM_W-1], front.sum};
        end
        cur_next = (sum_wide > $signed({1'b0, SUM_MAX})) ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        ctrl.op    = OP_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (expired) begin
                    ctrl.op = OP_SHIFT;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (advance) begin
                    ctrl.op    = last_reg ? OP_CLEAR : OP_UPDATE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ctrl.cur        = cur_reg;
        ctrl.idx        = item_index_reg;
        ctrl.cur_pos    = (cur_reg > 0);
        ctrl.shift_full = (cur_reg > 0) && keeps[WINDOW_DEPTH];
    end

    assign best_next = (cur_reg > best_reg) ? cur_reg : best_reg;

    // tail feed: new entry enters the last cell when a full queue shifts
    assign ents[WINDOW_DEPTH] = (ctrl.op == OP_UPDATE)
        ? entry_t'{valid: 1'b1, idx: item_index_reg, sum: cur_reg}
        : entry_t'{valid: 1'b0, idx: '0, sum: '0};
    assign keeps[0] = 1'b1;

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        wmss_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .right_in  (ents[i+1]),
            .left_keep (keeps[i]),
            .ent       (ents[i]),
            .keep      (keeps[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            item_index_reg <= '0;
            best_reg       <= MOST_NEG;
            window_reg     <= WIN_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    item_index_reg <= '0;
                    best_reg       <= MOST_NEG;
                end else begin
                    item_index_reg <= item_index_reg + IDX_W'(1);
                    best_reg       <= best_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            last_reg   <= s_tlast;
        end
        if (state_reg == ST_EXP && !expired) begin
            cur_reg <= cur_next;
        end
        if (advance) begin
            m_data_reg <= {best_next, cur_reg};
            m_last_reg <= last_reg;
        end
    end

endmodule

@@ test/windowed_max_subsequence_sum_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_max_subsequence_sum_tb
// Self-checking bench for the windowed maximum subsequence sum block. A class
// model keeps its own candidate queue, sample index and running maximum, and
// predicts one result per accepted sample. Each result transaction is checked
// field by field against the oldest prediction. The stimulus covers directed
// corners, one back-to-back run, and random sequences under changing window
// lengths. Both channels idle at random, and one long output stall backs the
// block up into its input.
// ----------------------------------------------------------------------------
module windowed_max_subsequence_sum_tb;
    import wmss_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          BURST_ITEMS  = 200;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    typedef enum int {
        SEQ_NOISE,
        SEQ_SMALL,
        SEQ_PLATEAU,
        SEQ_EXTREME
    } seq_kind_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_here;
        logic signed [SUM_W-1:0] best;
        logic                    last;
    } sum_result_t;

    class subseq_scoreboard;
        logic [IDX_W-1:0] cand_idx [DEPTH];
        longint           cand_val [DEPTH];
        int               cand_cnt;
        int               cand_head;
        logic [IDX_W-1:0] seq_pos;
        longint           best_so_far;
        int unsigned      window;
        int               errors;
        sum_result_t      expected_sums [$];

        function new();
            window = 1;
            errors = 0;
            restart_sequence();
        endfunction

        function void restart_sequence();
            cand_cnt    = 0;
            cand_head   = 0;
            seq_pos     = '0;
            best_so_far = -32768;
        endfunction

        function void set_window(logic [WIN_W-1:0] v);
            window = 32'(v);
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        function void take_sample(logic signed [15:0] x, logic last);
            int unsigned      win;
            logic [IDX_W-1:0] age;
            longint           cur;
            bit               expiring;
            int               s;
            sum_result_t      r;
            win = (window > DEPTH) ? DEPTH : window;
            expiring = 1'b1;
            while (expiring && cand_cnt > 0) begin
                age = seq_pos - cand_idx[cand_head];
                if (32'(age) > win) begin
                    cand_head = (cand_head + 1) % DEPTH;
                    cand_cnt--;
                end else begin
                    expiring = 1'b0;
                end
            end
            cur = x;
            if (cand_cnt > 0)
                cur += cand_val[cand_head];
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            if (cur > best_so_far)
                best_so_far = cur;
            while (cand_cnt > 0 && cand_val[(cand_head + cand_cnt - 1) % DEPTH] < cur)
                cand_cnt--;
            if (cur > 0) begin
                if (cand_cnt == DEPTH) begin
                    cand_head = (cand_head + 1) % DEPTH;
                    cand_cnt--;
                end
                s = (cand_head + cand_cnt) % DEPTH;
                cand_idx[s] = seq_pos;
                cand_val[s] = cur;
                cand_cnt++;
            end
            r.sum_here = cur[SUM_W-1:0];
            r.best     = best_so_far[SUM_W-1:0];
            r.last     = last;
            expected_sums = {expected_sums, r};
            seq_pos = seq_pos + IDX_W'(1);
            if (last)
                restart_sequence();
        endfunction

        function void check_result(logic signed [SUM_W-1:0] got_sum,
                                   logic signed [SUM_W-1:0] got_best,
                                   logic got_last);
            sum_result_t e;
            if (expected_sums.size() == 0) begin
                $error("unexpected result transaction: sum_ending_here %0d best_sum %0d",
                       got_sum, got_best);
                errors++;
                return;
            end
            e = expected_sums[0];
            expected_sums.delete(0);
            if (got_sum !== e.sum_here) begin
                $error("sum_ending_here mismatch: expected %0d, got %0d", e.sum_here, got_sum);
                errors++;
            end
            if (got_best !== e.best) begin
                $error("best_sum mismatch: expected %0d, got %0d", e.best, got_best);
                errors++;
            end
            if (got_last !== e.last) begin
                $error("is_final mismatch: expected %0b, got %0b", e.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // sample
    logic                   s_tlast   = 1'b0; // seq_end
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [2*SUM_W-1:0]     m_tdata;          // sum_ending_here, best_sum
    logic                   m_tlast;          // is_final
    logic                   cfg_we    = 1'b0;
    logic [WIN_W-1:0]       cfg_wdata = '0;   // window_len

    subseq_scoreboard sb = new();
    bit               quiet = 1'b0;
    int               items_sent;

    windowed_max_subsequence_sum #(
        .WINDOW_DEPTH (DEPTH),
        .SAMPLE_WIDTH (16)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd65;
            4: return 7'd127;
            5: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(2, 20));
        endcase
    endfunction

    task automatic send_sample(input logic signed [15:0] x, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_sample(x, last);
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_window(v);
    endtask

    task automatic send_sequence(input seq_kind_t kind, input int len, input bit close);
        logic signed [15:0] x;
        logic signed [15:0] step;
        logic               last;
        int                 i;
        step = 16'(-int'($urandom_range(1, 3)));
        for (i = 0; i < len; i++) begin
            last = 1'b0;
            case (kind)
                SEQ_NOISE: begin
                    x    = 16'($urandom);
                    last = ($urandom_range(0, 7) == 0);
                end
                SEQ_SMALL: x = 16'(int'($urandom_range(0, 400)) - 150);
                SEQ_PLATEAU: x = (i == 0) ? 16'sh7fff : step;
                default: begin
                    case ($urandom_range(0, 4))
                        0: x = 16'sh0000;
                        1, 2: x = 16'sh7fff;
                        default: x = 16'sh8000;
                    endcase
                end
            endcase
            if (close && i == len - 1)
                last = 1'b1;
            send_sample(x, last);
            items_sent++;
        end
    endtask

    // result side: random backpressure plus one long hold-off
    initial begin : result_sink
        int seen;
        int stall_left;
        bit held;
        int r;
        seen       = 0;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata[SUM_W-1:0], m_tdata[2*SUM_W-1:SUM_W], m_tlast);
                seen++;
            end
            if (!held && seen == 100) begin
                held       = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left = $urandom_range(8, 40);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= (r >= 28);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles == CYCLE_LIMIT) begin
                $display("windowed_max_subsequence_sum verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int        nseq;
        int        k;
        int        len;
        bit        close;
        seq_kind_t kind;
        items_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window of one
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
        // window zero
        write_window(7'd0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // window above depth
        write_window(7'd127);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd50, 1'b0);
        send_sample(-16'sd60, 1'b0);
        send_sample(16'sd30, 1'b1);
        // shrink the window in the middle of a sequence
        write_window(7'd3);
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd20, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(-16'sd5, 1'b0);
        write_window(7'd1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        write_window(7'd64);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd1, 1'b1);

        // back-to-back run; the long output hold-off lands inside it
        quiet = 1'b1;
        send_sequence(SEQ_SMALL, BURST_ITEMS, 1'b1);

        while (items_sent < RANDOM_ITEMS) begin
            write_window(pick_window());
            quiet = ($urandom_range(0, 3) == 0);
            nseq  = $urandom_range(2, 6);
            for (k = 0; k < nseq; k++) begin
                case ($urandom_range(0, 9))
                    0, 1:    kind = SEQ_NOISE;
                    2, 3, 4: kind = SEQ_SMALL;
                    5, 6:    kind = (sb.window >= DEPTH) ? SEQ_PLATEAU : SEQ_SMALL;
                    7:       kind = SEQ_PLATEAU;
                    default: kind = SEQ_EXTREME;
                endcase
                len   = (kind == SEQ_PLATEAU) ? $urandom_range(66, 100) : $urandom_range(1, 40);
                close = !(k == nseq - 1 && $urandom_range(0, 3) == 0);
                send_sequence(kind, len, close);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("windowed_max_subsequence_sum verification clean");
        end else begin
            $display("windowed_max_subsequence_sum verification failed");
        end
        $finish;
    end

endmodule
